// ===== hdl/memory_map_region_decoder_defines.svh =====
// Assertion macros shared by the region decoder RTL.
`ifndef MEMORY_MAP_REGION_DECODER_DEFINES_SVH
`define MEMORY_MAP_REGION_DECODER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MMRD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MMRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mmrd_pkg.sv =====
// Types, constants and payload layouts of the region decoder.
`timescale 1ns / 1ps
`default_nettype none
package mmrd_pkg;

	localparam int ENTRIES   = 16;
	localparam int ADDR_BITS = 24;

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int END_W   = ADDR_BITS + 1;
	localparam int SIZE_W  = ADDR_BITS + 1;
	localparam int SUM_W   = ADDR_BITS + 5;
	localparam int FLAGS_W = 8;
	localparam int GROUP   = 4;
	localparam int GROUPS  = (ENTRIES + GROUP - 1) / GROUP;
	localparam int PART_W  = SIZE_W + 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = ADDR_BITS;
	localparam int ENTRIES_REG_W = 5;

	// Flag bit positions
	localparam int FL_READ      = 0;
	localparam int FL_ODD       = 1;
	localparam int FL_EVEN      = 2;
	localparam int FL_FUNC_NULL = 3;

	localparam logic [ADDR_BITS-1:0] ADDR_MASK_RESET = {ADDR_BITS{1'b1}};

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_e;

	typedef enum logic [1:0] {
		LANE_FULL = 2'd0,
		LANE_ODD  = 2'd1,
		LANE_EVEN = 2'd2
	} lane_e;

	typedef enum logic [1:0] {
		ROUTE_NONE    = 2'd0,
		ROUTE_MEM     = 2'd1,
		ROUTE_HANDLER = 2'd2
	} route_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOKUP_MASK    = 2'd0,
		CFG_ENTRIES_IN_USE = 2'd1
	} cfg_reg_e;

	// One region entry as held in the table
	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [END_W-1:0]     region_end;
		logic [ADDR_BITS-1:0] mask;
		logic [FLAGS_W-1:0]   flags;
		logic                 base;
		logic                 handler;
	} entry_t;

	// Input payload, first member is the top bits
	localparam int IN_FIELDS_W = 4 + ADDR_BITS + END_W + ADDR_BITS + FLAGS_W + 2
		+ ADDR_BITS + FLAGS_W;
	localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_PAD_W  = IN_DATA_W - IN_FIELDS_W;

	typedef struct packed {
		logic [IN_PAD_W-1:0]  pad;
		logic [FLAGS_W-1:0]   required_flags;
		logic [ADDR_BITS-1:0] lookup_address;
		logic                 handler_present;
		logic                 base_present;
		logic [FLAGS_W-1:0]   region_flags;
		logic [ADDR_BITS-1:0] region_mask;
		logic [END_W-1:0]     region_end;
		logic [ADDR_BITS-1:0] region_start;
		logic [3:0]           entry_index;
	} in_tdata_t;

	// Output payload, first member is the top bits
	localparam int OUT_FIELDS_W = 1 + 4 + ADDR_BITS + 2 + 2 + SUM_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FIELDS_W;

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [SUM_W-1:0]     size_before;
		logic [1:0]           route;
		logic [1:0]           lane_mode;
		logic [ADDR_BITS-1:0] offset;
		logic [3:0]           region_index;
		logic                 hit;
	} out_tdata_t;

	// Match stage: selected entry and per-entry sizes
	typedef struct packed {
		logic                              found;
		logic [IDX_W-1:0]                  idx;
		entry_t                            sel;
		logic [ADDR_BITS-1:0]              raw;
		logic [ENTRIES-1:0]                below;
		logic [ENTRIES-1:0][SIZE_W-1:0]    size;
	} match_t;

	// Decoded result of a lookup, without the size sum
	typedef struct packed {
		logic                 hit;
		logic [IDX_W-1:0]     idx;
		logic [ADDR_BITS-1:0] offset;
		lane_e                lane;
		route_e               route;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/memory_map_region_decoder.sv =====
// Top level of the memory-map region decoder: handshake, pipeline control, config.
//
// The decoder takes one transaction per clock on the slave stream while the
// output is not stalled, and returns exactly one result per transaction on the
// master stream; each transaction passes through registers s1, s2, s3 and s4 in
// that order, and the result is driven from s4.
// A load (tuser = 0) writes one region entry and returns an all-zero result;
// a lookup (tuser = 1) searches entries 0 .. min(entries_in_use, 16)-1 for the first
// region with start <= (address & lookup mask) < end and reports hit, index,
// offset, byte-lane mode, route and the summed size of earlier regions that
// carry every required flag. A load is visible to every lookup accepted after
// it. The search in s1 compares all sixteen table entries in parallel, and the
// size sum of the flagged earlier regions runs as a two-level registered
// tree over s2 and s3. The whole pipeline holds while a result waits on
// m_tready, so s_tready follows m_tready combinationally. Table contents are
// not reset: look up only entries that have been loaded. Configuration writes
// are always ready and must be issued only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
`include "memory_map_region_decoder_defines.svh"
module memory_map_region_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// slave stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// tdata, low bit up: entry_index, region_start, region_end, region_mask,
	// region_flags, base_present, handler_present, lookup_address, required_flags
	input  wire logic [mmrd_pkg::IN_DATA_W-1:0]    s_tdata,
	// tuser: cmd
	input  wire logic                              s_tuser,
	// master stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// tdata, low bit up: hit, region_index, offset, lane_mode, route, size_before
	output logic [mmrd_pkg::OUT_DATA_W-1:0]        m_tdata,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mmrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mmrd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mmrd_pkg::*;

	in_tdata_t                     in_d;
	out_tdata_t                    out_d;
	logic                          en;
	logic                          accept;

	logic [ADDR_BITS-1:0]          lookup_mask_q;
	logic [ENTRIES_REG_W-1:0]      entries_in_use_q;
	logic [CNT_W-1:0]              count;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          lookup_s1;
	logic [ADDR_BITS-1:0]          raw_s1;
	logic [ADDR_BITS-1:0]          addr_s1;
	logic [FLAGS_W-1:0]            req_s1;

	entry_t                        wr_entry;
	match_t                        match_s2;
	result_t                       result_s3;
	result_t                       result_s4;
	logic [GROUPS-1:0][PART_W-1:0] part_s3;
	logic [SUM_W-1:0]              sum_s4;

	assign in_d = in_tdata_t'(s_tdata);

	// Advance every stage together unless the result register is held
	assign en       = !valid_s4 || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Saturate the entry count at the table depth
	assign count = (entries_in_use_q > ENTRIES_REG_W'(ENTRIES))
		? CNT_W'(ENTRIES) : CNT_W'(entries_in_use_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_mask_q    <= ADDR_MASK_RESET;
			entries_in_use_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOOKUP_MASK:    lookup_mask_q    <= cfg_data;
				CFG_ENTRIES_IN_USE: entries_in_use_q <= cfg_data[ENTRIES_REG_W-1:0];
				default: ; // drop writes to unknown registers
			endcase
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1 payload; a bubble is held as a load so it matches nothing
	always_ff @(posedge clk) begin
		if (en) begin
			lookup_s1 <= s_tvalid && (cmd_e'(s_tuser) == CMD_LOOKUP);
			raw_s1    <= in_d.lookup_address;
			addr_s1   <= in_d.lookup_address & lookup_mask_q;
			req_s1    <= in_d.required_flags;
		end
	end

	assign wr_entry.start      = in_d.region_start;
	assign wr_entry.region_end = in_d.region_end;
	assign wr_entry.mask       = in_d.region_mask;
	assign wr_entry.flags      = in_d.region_flags;
	assign wr_entry.base       = in_d.base_present;
	assign wr_entry.handler    = in_d.handler_present;

	mmrd_table u_table (
		.clk          (clk),
		.en           (en),
		.wr_en        (accept && (cmd_e'(s_tuser) == CMD_LOAD)),
		.wr_idx       (IDX_W'(in_d.entry_index)),
		.wr_entry     (wr_entry),
		.lookup_s1    (lookup_s1),
		.raw_s1       (raw_s1),
		.addr_s1      (addr_s1),
		.req_s1       (req_s1),
		.count        (count),
		.lookup_mask  (lookup_mask_q),
		.match_s2     (match_s2)
	);

	mmrd_resolve u_resolve (
		.clk       (clk),
		.en        (en),
		.match_s2  (match_s2),
		.result_s3 (result_s3),
		.part_s3   (part_s3)
	);

	mmrd_accum u_accum (
		.clk       (clk),
		.en        (en),
		.result_s3 (result_s3),
		.part_s3   (part_s3),
		.result_s4 (result_s4),
		.sum_s4    (sum_s4)
	);

	always_comb begin
		out_d              = '0;
		out_d.hit          = result_s4.hit;
		out_d.region_index = 4'(result_s4.idx);
		out_d.offset       = result_s4.offset;
		out_d.lane_mode    = result_s4.lane;
		out_d.route        = result_s4.route;
		out_d.size_before  = sum_s4;
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = out_d;

	// A miss carries nothing but the size sum
	`MMRD_ASSERT_SAME(a_miss_zero, m_tvalid && !result_s4.hit,
		result_s4.route == ROUTE_NONE && result_s4.lane == LANE_FULL
		&& result_s4.offset == '0 && result_s4.idx == '0,
		"miss result carries non-zero decode fields")
	// Byte-lane modes exist on the memory route only
	`MMRD_ASSERT_SAME(a_lane_mem, m_tvalid && result_s4.lane != LANE_FULL,
		result_s4.route == ROUTE_MEM, "lane mode set off the memory route")
	// No transaction enters while a result is held
	`MMRD_ASSERT_SAME(a_stall_blocks, m_tvalid && !m_tready, !s_tready,
		"input accepted while output stalled")
	// A held result leaves the pipeline valid bits untouched
	`MMRD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
		m_tvalid && $stable(valid_s3) && $stable(valid_s2) && $stable(valid_s1),
		"pipeline moved during a stall")

endmodule
`default_nettype wire

// ===== hdl/mmrd_table.sv =====
// Region table storage and first-match search over all entries.
`timescale 1ns / 1ps
`default_nettype none
module mmrd_table (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic                           wr_en,
	input  wire logic [mmrd_pkg::IDX_W-1:0]     wr_idx,
	input  wire mmrd_pkg::entry_t               wr_entry,
	input  wire logic                           lookup_s1,
	input  wire logic [mmrd_pkg::ADDR_BITS-1:0] raw_s1,
	input  wire logic [mmrd_pkg::ADDR_BITS-1:0] addr_s1,
	input  wire logic [mmrd_pkg::FLAGS_W-1:0]   req_s1,
	input  wire logic [mmrd_pkg::CNT_W-1:0]     count,
	input  wire logic [mmrd_pkg::ADDR_BITS-1:0] lookup_mask,
	output mmrd_pkg::match_t                    match_s2
);
	import mmrd_pkg::*;

	entry_t tbl_q [ENTRIES];

	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] first;
	match_t             match_d;

	function automatic logic [SIZE_W-1:0] size_of(entry_t e, logic [ADDR_BITS-1:0] am);
		logic [END_W-1:0] s;
		s = {1'b0, e.start};
		if (e.mask == am) begin
			size_of = (e.region_end < s) ? '0 : SIZE_W'(e.region_end - s);
		end else begin
			size_of = SIZE_W'({1'b0, e.mask} + END_W'(1));
		end
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[wr_idx] <= wr_entry;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			logic active;
			active = lookup_s1 && (CNT_W'(i) < count);
			hit_vec[i] = active && (addr_s1 >= tbl_q[i].start)
				&& ({1'b0, addr_s1} < tbl_q[i].region_end);
			match_d.size[i] = (active && ((tbl_q[i].flags & req_s1) == req_s1))
				? size_of(tbl_q[i], lookup_mask) : '0;
		end
		// isolate the lowest hit; entries below it are those before the match
		first = hit_vec & (~hit_vec + ENTRIES'(1));
		match_d.below = first - ENTRIES'(1);
		match_d.found = |hit_vec;
		match_d.raw   = raw_s1;
		match_d.idx   = '0;
		match_d.sel   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_d.idx = match_d.idx | (first[i] ? IDX_W'(i) : '0);
			match_d.sel = match_d.sel | (first[i] ? tbl_q[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			match_s2 <= match_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mmrd_resolve.sv =====
// Offset, lane mode and route of the matched region; partial size sums.
`timescale 1ns / 1ps
`default_nettype none
module mmrd_resolve (
	input  wire logic                                      clk,
	input  wire logic                                      en,
	input  wire mmrd_pkg::match_t                          match_s2,
	output mmrd_pkg::result_t                              result_s3,
	output logic [mmrd_pkg::GROUPS-1:0][mmrd_pkg::PART_W-1:0] part_s3
);
	import mmrd_pkg::*;

	result_t                       res_d;
	logic [GROUPS-1:0][PART_W-1:0] part_d;
	logic [ADDR_BITS-1:0]          off;
	logic [FLAGS_W-1:0]            fl;

	always_comb begin
		fl  = match_s2.sel.flags;
		off = (match_s2.raw - match_s2.sel.start) & match_s2.sel.mask;
		res_d.hit    = match_s2.found;
		res_d.idx    = match_s2.idx;
		res_d.offset = off;
		res_d.lane   = LANE_FULL;
		res_d.route  = ROUTE_NONE;
		priority if (fl[FL_READ] && match_s2.sel.base) begin
			res_d.route = ROUTE_MEM;
			priority if (fl[FL_ODD]) begin
				res_d.lane   = LANE_ODD;
				res_d.offset = off >> 1;
			end else if (fl[FL_EVEN]) begin
				res_d.lane   = LANE_EVEN;
				res_d.offset = off >> 1;
			end else begin
				res_d.lane   = LANE_FULL;
			end
		end else if ((!fl[FL_READ] || fl[FL_FUNC_NULL]) && match_s2.sel.handler) begin
			res_d.route = ROUTE_HANDLER;
		end else begin
			res_d.route = ROUTE_NONE;
		end
		// a miss reports zeros everywhere but the sum
		if (!match_s2.found) begin
			res_d = '0;
		end

		for (int g = 0; g < GROUPS; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < ENTRIES) begin
					part_d[g] = part_d[g] + PART_W'(match_s2.size[g * GROUP + k]
						& {SIZE_W{match_s2.below[g * GROUP + k]}});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s3 <= res_d;
			part_s3   <= part_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mmrd_accum.sv =====
// Final size sum and output register of the result.
`timescale 1ns / 1ps
`default_nettype none
module mmrd_accum (
	input  wire logic                                         clk,
	input  wire logic                                         en,
	input  wire mmrd_pkg::result_t                            result_s3,
	input  wire logic [mmrd_pkg::GROUPS-1:0][mmrd_pkg::PART_W-1:0] part_s3,
	output mmrd_pkg::result_t                                 result_s4,
	output logic [mmrd_pkg::SUM_W-1:0]                        sum_s4
);
	import mmrd_pkg::*;

	logic [SUM_W-1:0] sum_d;

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < GROUPS; g++) begin
			sum_d = sum_d + SUM_W'(part_s3[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s4 <= result_s3;
			sum_s4    <= sum_d;
		end
	end

endmodule
`default_nettype wire
